// File: rtl/aacr_pkg.sv
// Shared types, constants and helpers for the AABB axis collision resolver.
// Used by the core and the port checker; no dependencies.
package aacr_pkg;

   localparam int COLLIDERS_DEFAULT = 8;

   // Body extents in Q16.16: 0.35 and 0.90.
   localparam logic [30:0] HALF_WIDTH_RESET  = 31'd22938;
   localparam logic [30:0] HALF_HEIGHT_RESET = 31'd58982;

   // 0.0001 in Q16.16 is 6.55 LSB; an overlap must exceed this.
   localparam logic signed [34:0] EPS_Q = 35'sd6;

   localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
   localparam logic signed [33:0] POS_MIN = -34'sd2147483648;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WIDTH       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_HEIGHT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_COLLIDERS = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE_BOX = 2'd0,
      OP_SET_POS   = 2'd1,
      OP_MOVE      = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BOX,
      ST_CMP,
      ST_EVAL
   } st_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [2:0]         slot;
      logic [2:0]         axis_mask;
      logic signed [31:0] coord_ax;
      logic signed [31:0] coord_ay;
      logic signed [31:0] coord_az;
      logic signed [31:0] coord_bx;
      logic signed [31:0] coord_by;
      logic signed [31:0] coord_bz;
      logic [1:0]         move_axis;
      logic signed [31:0] move_delta;
   } req_type;

   typedef struct packed {
      logic signed [31:0] body_x;
      logic signed [31:0] body_y;
      logic signed [31:0] body_z;
      logic               axis_hit;
      logic               landed;
   } rsp_type;

   typedef struct packed {
      logic [2:0]         axes;
      logic signed [31:0] lo_x;
      logic signed [31:0] lo_y;
      logic signed [31:0] lo_z;
      logic signed [31:0] hi_x;
      logic signed [31:0] hi_y;
      logic signed [31:0] hi_z;
   } box_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [33:0] r;
      if (v > POS_MAX) begin
         r = POS_MAX;
      end else if (v < POS_MIN) begin
         r = POS_MIN;
      end else begin
         r = v;
      end
      return r[31:0];
   endfunction

endpackage

// File: rtl/aacr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the collider table of the resolver core.
module aacr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/aabb_axis_collision_resolve_core.sv
// Top level of the AABB axis collision resolver: command interface, CSRs,
// body position and collider walk. Depends on aacr_pkg and aacr_ram.

// One word in, one word out. Collider writes, position sets, opcode three and
// moves with a zero delta or axis three give their result word in the cycle
// after start is taken, and busy stays low, so a new word can be taken at once.
// A real move walks min(active_colliders, COLLIDERS) table entries in order;
// each entry passes through ST_BOX (table read), ST_CMP (bound compare) and
// ST_EVAL (overlap test and push) before the next, which needs the position
// left by this one. busy stays high for the whole walk, so no new word is taken
// until the walk ends. The result strobe lasts one cycle and cannot be held off.
module aabb_axis_collision_resolve_core #(
   parameter int COLLIDERS = aacr_pkg::COLLIDERS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  aacr_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   output aacr_pkg::rsp_type                   rsp_item,
   input  logic                                csr_we,
   input  logic [aacr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [aacr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import aacr_pkg::*;

   localparam int AW = $clog2(COLLIDERS > 1 ? COLLIDERS : 2);
   localparam int CW = $clog2(COLLIDERS + 1);
   localparam int NW = CW > 4 ? CW : 4;

   st_type              state_ff, state_in;
   logic [30:0]         half_width_ff, half_width_in;
   logic [30:0]         half_height_ff, half_height_in;
   logic [3:0]          active_ff, active_in;
   logic signed [31:0]  pos_x_ff, pos_x_in;
   logic signed [31:0]  pos_y_ff, pos_y_in;
   logic signed [31:0]  pos_z_ff, pos_z_in;
   logic [1:0]          axis_ff, axis_in;
   logic                neg_ff, neg_in;
   logic                hit_ff, hit_in;
   logic                land_ff, land_in;
   logic [NW-1:0]       idx_ff, idx_in;
   logic signed [33:0]  mv_lo_ff [3];
   logic signed [33:0]  mv_lo_in [3];
   logic signed [33:0]  mv_hi_ff [3];
   logic signed [33:0]  mv_hi_in [3];
   logic signed [33:0]  top_ff [3];
   logic signed [33:0]  top_in [3];
   logic signed [33:0]  bot_ff [3];
   logic signed [33:0]  bot_in [3];
   logic                touch_ff, touch_in;
   logic                mask_ff, mask_in;
   logic signed [33:0]  push_ff, push_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_item_ff, rsp_item_in;

   logic                accept;
   logic                slot_ok;
   logic [NW-1:0]       n_active;
   logic signed [33:0]  hw34, hh2;
   logic signed [33:0]  c_lo [3];
   logic signed [33:0]  c_hi [3];
   logic signed [34:0]  ov [3];
   logic [2:0]          ov_ok;
   logic                side_ok;
   logic signed [31:0]  pos_sel;
   logic signed [33:0]  moved;
   logic                respond;
   logic                ram_we;
   logic                ram_re;
   box_type             box_wr;
   box_type             box_rd;

   assign busy    = state_ff != ST_IDLE;
   assign accept  = start && !busy;
   assign slot_ok = 32'(req_item.slot) < COLLIDERS;
   assign n_active = (32'(active_ff) > COLLIDERS) ? NW'(COLLIDERS) : NW'(active_ff);
   assign hw34    = signed'({3'b000, half_width_ff});
   assign hh2     = signed'({2'b00, half_height_ff, 1'b0});

   assign box_wr.axes = req_item.axis_mask;
   assign box_wr.lo_x = req_item.coord_ax;
   assign box_wr.lo_y = req_item.coord_ay;
   assign box_wr.lo_z = req_item.coord_az;
   assign box_wr.hi_x = req_item.coord_bx;
   assign box_wr.hi_y = req_item.coord_by;
   assign box_wr.hi_z = req_item.coord_bz;

   assign c_lo[0] = 34'(box_rd.lo_x);
   assign c_lo[1] = 34'(box_rd.lo_y);
   assign c_lo[2] = 34'(box_rd.lo_z);
   assign c_hi[0] = 34'(box_rd.hi_x);
   assign c_hi[1] = 34'(box_rd.hi_y);
   assign c_hi[2] = 34'(box_rd.hi_z);

   aacr_ram #(
      .WIDTH ($bits(box_type)),
      .DEPTH (COLLIDERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(req_item.slot)),
      .wr_data (box_wr),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (box_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         half_width_ff  <= HALF_WIDTH_RESET;
         half_height_ff <= HALF_HEIGHT_RESET;
         active_ff      <= 4'd0;
         pos_x_ff       <= 32'sd0;
         pos_y_ff       <= 32'sd0;
         pos_z_ff       <= 32'sd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         half_width_ff  <= half_width_in;
         half_height_ff <= half_height_in;
         active_ff      <= active_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         pos_z_ff       <= pos_z_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      neg_ff      <= neg_in;
      hit_ff      <= hit_in;
      land_ff     <= land_in;
      idx_ff      <= idx_in;
      mv_lo_ff    <= mv_lo_in;
      mv_hi_ff    <= mv_hi_in;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      touch_ff    <= touch_in;
      mask_ff     <= mask_in;
      push_ff     <= push_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Overlap on each axis of the last compared entry, then the two side axes.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         ov[a]    = 35'(top_ff[a]) - 35'(bot_ff[a]);
         ov_ok[a] = ov[a] > EPS_Q;
      end
      case (axis_ff)
         AXIS_X:  side_ok = ov_ok[1] && ov_ok[2];
         AXIS_Y:  side_ok = ov_ok[0] && ov_ok[2];
         AXIS_Z:  side_ok = ov_ok[0] && ov_ok[1];
         default: side_ok = 1'b0;
      endcase
   end

   always_comb begin
      case (req_item.move_axis)
         AXIS_X:  pos_sel = pos_x_ff;
         AXIS_Y:  pos_sel = pos_y_ff;
         default: pos_sel = pos_z_ff;
      endcase
      moved = 34'(pos_sel) + 34'(req_item.move_delta);
   end

   always_comb begin
      state_in       = state_ff;
      half_width_in  = half_width_ff;
      half_height_in = half_height_ff;
      active_in      = active_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      pos_z_in       = pos_z_ff;
      axis_in        = axis_ff;
      neg_in         = neg_ff;
      hit_in         = hit_ff;
      land_in        = land_ff;
      idx_in         = idx_ff;
      mv_lo_in       = mv_lo_ff;
      mv_hi_in       = mv_hi_ff;
      top_in         = top_ff;
      bot_in         = bot_ff;
      touch_in       = touch_ff;
      mask_in        = mask_ff;
      push_in        = push_ff;
      rsp_item_in    = rsp_item_ff;
      rsp_valid_in   = 1'b0;
      respond        = 1'b0;
      ram_we         = 1'b0;
      ram_re         = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_HALF_WIDTH:       half_width_in  = csr_wdata;
            CSR_HALF_HEIGHT:      half_height_in = csr_wdata;
            CSR_ACTIVE_COLLIDERS: active_in      = csr_wdata[3:0];
            default:              ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hit_in  = 1'b0;
               land_in = 1'b0;
               respond = 1'b1;
               case (req_item.opcode)
                  OP_WRITE_BOX: ram_we = slot_ok;
                  OP_SET_POS: begin
                     pos_x_in = req_item.coord_ax;
                     pos_y_in = req_item.coord_ay;
                     pos_z_in = req_item.coord_az;
                  end
                  OP_MOVE: begin
                     if (req_item.move_axis != AXIS_NONE && req_item.move_delta != 32'sd0) begin
                        respond  = 1'b0;
                        axis_in  = req_item.move_axis;
                        neg_in   = req_item.move_delta[31];
                        idx_in   = '0;
                        state_in = ST_BOX;
                        case (req_item.move_axis)
                           AXIS_X:  pos_x_in = sat32(moved);
                           AXIS_Y:  pos_y_in = sat32(moved);
                           default: pos_z_in = sat32(moved);
                        endcase
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_BOX: begin
            // Rebuild the body box from the current position; fetch the entry.
            mv_lo_in[0] = 34'(pos_x_ff) - hw34;
            mv_hi_in[0] = 34'(pos_x_ff) + hw34;
            mv_lo_in[1] = 34'(pos_y_ff);
            mv_hi_in[1] = 34'(pos_y_ff) + hh2;
            mv_lo_in[2] = 34'(pos_z_ff) - hw34;
            mv_hi_in[2] = 34'(pos_z_ff) + hw34;
            if (idx_ff == n_active) begin
               respond  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ram_re   = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            touch_in = 1'b1;
            for (int a = 0; a < 3; a++) begin
               if (!(mv_lo_ff[a] <= c_hi[a] && mv_hi_ff[a] >= c_lo[a])) begin
                  touch_in = 1'b0;
               end
               top_in[a] = (mv_hi_ff[a] < c_hi[a]) ? mv_hi_ff[a] : c_hi[a];
               bot_in[a] = (mv_lo_ff[a] > c_lo[a]) ? mv_lo_ff[a] : c_lo[a];
            end
            mask_in = box_rd.axes[axis_ff];
            // Flush position against the face that the body entered.
            case (axis_ff)
               AXIS_X:  push_in = neg_ff ? c_hi[0] + hw34 : c_lo[0] - hw34;
               AXIS_Y:  push_in = neg_ff ? c_hi[1] : c_lo[1] - hh2;
               default: push_in = neg_ff ? c_hi[2] + hw34 : c_lo[2] - hw34;
            endcase
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (mask_ff && touch_ff && side_ok) begin
               hit_in = 1'b1;
               case (axis_ff)
                  AXIS_X:  pos_x_in = sat32(push_ff);
                  AXIS_Y: begin
                     pos_y_in = sat32(push_ff);
                     if (neg_ff) begin
                        land_in = 1'b1;
                     end
                  end
                  default: pos_z_in = sat32(push_ff);
               endcase
            end
            idx_in   = idx_ff + 1'b1;
            state_in = ST_BOX;
         end
         default: state_in = ST_IDLE;
      endcase

      if (respond) begin
         rsp_valid_in         = 1'b1;
         rsp_item_in.body_x   = pos_x_in;
         rsp_item_in.body_y   = pos_y_in;
         rsp_item_in.body_z   = pos_z_in;
         rsp_item_in.axis_hit = hit_in;
         rsp_item_in.landed   = land_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: rtl/aacr_checker.sv
// Port-level checker for the AABB axis collision resolver, bound to the core.
// Depends on aacr_pkg and the aabb_axis_collision_resolve_core port list.
module aacr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input aacr_pkg::req_type                req_item,
   input logic                             rsp_valid,
   input aacr_pkg::rsp_type                rsp_item
);
   import aacr_pkg::*;

   // Any word other than a move answers in the next cycle with no flags.
   a_plain_word: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.opcode != OP_MOVE
      |=> rsp_valid && !rsp_item.axis_hit && !rsp_item.landed)
      else $error("non-move word did not answer cleanly");

   a_set_pos: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.opcode == OP_SET_POS
      |=> rsp_item.body_x == $past(req_item.coord_ax)
          && rsp_item.body_y == $past(req_item.coord_ay)
          && rsp_item.body_z == $past(req_item.coord_az))
      else $error("set position not reflected");

   a_land_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.landed |-> rsp_item.axis_hit)
      else $error("landing without hit");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while walking");

   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start");

endmodule

bind aabb_axis_collision_resolve_core aacr_checker u_aacr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

// File: tb/tb_top.sv
// Testbench for aabb_axis_collision_resolve_core: directed and random command words,
// predicted against a behavioral copy of the collider walk kept in this file.
// Depends on aacr_pkg and the core RTL only.
module tb_top;
   import aacr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLLIDERS = COLLIDERS_DEFAULT;
   localparam int UNIT_Q = 65536;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 30;
   localparam longint OVERLAP_EPS = 6;
   localparam longint POS_HI = 64'sd2147483647;
   localparam longint POS_LO = -64'sd2147483648;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;
   localparam logic [1:0] OP_NOP = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_item;
   logic rsp_valid;
   rsp_type rsp_item;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow of the collider table, body position and registers
   longint box_lo [COLLIDERS][3];
   longint box_hi [COLLIDERS][3];
   logic [2:0] box_axes [COLLIDERS];
   longint body_pos [3];
   longint half_w;
   longint half_h;
   int live_boxes;

   rsp_type body_state_q [$];
   rsp_type due_body;
   int fault_count = 0;
   int cycle_count = 0;

   aabb_axis_collision_resolve_core DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint wide(input logic signed [31:0] v);
      return longint'(v);
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > POS_HI) return POS_HI;
      if (v < POS_LO) return POS_LO;
      return v;
   endfunction

   // Apply one command word to the shadow state and return the body word it yields.
   function automatic rsp_type resolve_word(input req_type w);
      rsp_type r;
      longint delta;
      longint lo [3];
      longint hi [3];
      longint ovl [3];
      longint top;
      longint bot;
      int ax;
      int o1;
      int o2;
      int n;
      logic touch;
      r.axis_hit = 1'b0;
      r.landed = 1'b0;
      case (w.opcode)
         OP_WRITE_BOX: begin
            box_axes[w.slot] = w.axis_mask;
            box_lo[w.slot][0] = wide(w.coord_ax);
            box_lo[w.slot][1] = wide(w.coord_ay);
            box_lo[w.slot][2] = wide(w.coord_az);
            box_hi[w.slot][0] = wide(w.coord_bx);
            box_hi[w.slot][1] = wide(w.coord_by);
            box_hi[w.slot][2] = wide(w.coord_bz);
         end
         OP_SET_POS: begin
            body_pos[0] = wide(w.coord_ax);
            body_pos[1] = wide(w.coord_ay);
            body_pos[2] = wide(w.coord_az);
         end
         OP_MOVE: begin
            ax = int'(w.move_axis);
            delta = wide(w.move_delta);
            if (w.move_axis != AXIS_NONE && delta != 0) begin
               body_pos[ax] = clamp32(body_pos[ax] + delta);
               n = (live_boxes > COLLIDERS) ? COLLIDERS : live_boxes;
               o1 = (ax == 0) ? 1 : 0;
               o2 = (ax == 2) ? 1 : 2;
               for (int i = 0; i < n; i++) begin
                  if (box_axes[i][ax]) begin
                     // body box is rebuilt from the position left by the previous entry
                     lo[0] = body_pos[0] - half_w;
                     hi[0] = body_pos[0] + half_w;
                     lo[1] = body_pos[1];
                     hi[1] = body_pos[1] + 2 * half_h;
                     lo[2] = body_pos[2] - half_w;
                     hi[2] = body_pos[2] + half_w;
                     touch = 1'b1;
                     for (int a = 0; a < 3; a++) begin
                        if (!(lo[a] <= box_hi[i][a] && hi[a] >= box_lo[i][a])) touch = 1'b0;
                        top = (hi[a] < box_hi[i][a]) ? hi[a] : box_hi[i][a];
                        bot = (lo[a] > box_lo[i][a]) ? lo[a] : box_lo[i][a];
                        ovl[a] = top - bot;
                     end
                     if (touch && ovl[o1] > OVERLAP_EPS && ovl[o2] > OVERLAP_EPS) begin
                        if (delta > 0) begin
                           body_pos[ax] = clamp32(box_lo[i][ax] -
                              ((w.move_axis == AXIS_Y) ? 2 * half_h : half_w));
                        end else begin
                           body_pos[ax] = clamp32(box_hi[i][ax] +
                              ((w.move_axis == AXIS_Y) ? 64'sd0 : half_w));
                           if (w.move_axis == AXIS_Y) r.landed = 1'b1;
                        end
                        r.axis_hit = 1'b1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      r.body_x = body_pos[0][31:0];
      r.body_y = body_pos[1][31:0];
      r.body_z = body_pos[2][31:0];
      return r;
   endfunction

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("ERROR: %s", msg);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (body_state_q.size() == 0) begin
            note_fault($sformatf("body word with nothing pending: %0d %0d %0d hit %b land %b",
               rsp_item.body_x, rsp_item.body_y, rsp_item.body_z,
               rsp_item.axis_hit, rsp_item.landed));
         end else begin
            due_body = body_state_q.pop_front();
            if (rsp_item.body_x !== due_body.body_x || rsp_item.body_y !== due_body.body_y ||
                rsp_item.body_z !== due_body.body_z || rsp_item.axis_hit !== due_body.axis_hit ||
                rsp_item.landed !== due_body.landed) begin
               note_fault($sformatf(
                  "got %0d %0d %0d hit %b land %b, want %0d %0d %0d hit %b land %b",
                  rsp_item.body_x, rsp_item.body_y, rsp_item.body_z,
                  rsp_item.axis_hit, rsp_item.landed,
                  due_body.body_x, due_body.body_y, due_body.body_z,
                  due_body.axis_hit, due_body.landed));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Present one word and hold it until the core takes it; start stays high.
   task automatic send_word(input req_type w);
      req_item <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      body_state_q.push_back(resolve_word(w));
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (body_state_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [30:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_HALF_WIDTH: half_w = longint'(val);
         CSR_HALF_HEIGHT: half_h = longint'(val);
         CSR_ACTIVE_COLLIDERS: live_boxes = int'(val[3:0]);
         default: ;
      endcase
   endtask

   // Only call with the core idle.
   task automatic load_regs(input logic [30:0] hw, input logic [30:0] hh,
                            input logic [30:0] act);
      write_reg(CSR_HALF_WIDTH, hw);
      write_reg(CSR_HALF_HEIGHT, hh);
      write_reg(CSR_ACTIVE_COLLIDERS, act);
      write_reg(CSR_SPARE, 31'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic req_type noise_word();
      req_type w;
      w.opcode = 2'($urandom);
      w.slot = 3'($urandom);
      w.axis_mask = 3'($urandom);
      w.coord_ax = $urandom;
      w.coord_ay = $urandom;
      w.coord_az = $urandom;
      w.coord_bx = $urandom;
      w.coord_by = $urandom;
      w.coord_bz = $urandom;
      w.move_axis = 2'($urandom);
      w.move_delta = $urandom;
      return w;
   endfunction

   function automatic req_type box_word(input logic [2:0] slot, input logic [2:0] mask,
      input logic signed [31:0] lx, input logic signed [31:0] ly, input logic signed [31:0] lz,
      input logic signed [31:0] hx, input logic signed [31:0] hy, input logic signed [31:0] hz);
      req_type w;
      w = noise_word();
      w.opcode = OP_WRITE_BOX;
      w.slot = slot;
      w.axis_mask = mask;
      w.coord_ax = lx;
      w.coord_ay = ly;
      w.coord_az = lz;
      w.coord_bx = hx;
      w.coord_by = hy;
      w.coord_bz = hz;
      return w;
   endfunction

   function automatic req_type pos_word(input logic signed [31:0] x,
      input logic signed [31:0] y, input logic signed [31:0] z);
      req_type w;
      w = noise_word();
      w.opcode = OP_SET_POS;
      w.coord_ax = x;
      w.coord_ay = y;
      w.coord_az = z;
      return w;
   endfunction

   function automatic req_type move_word(input logic [1:0] axis,
                                         input logic signed [31:0] delta);
      req_type w;
      w = noise_word();
      w.opcode = OP_MOVE;
      w.move_axis = axis;
      w.move_delta = delta;
      return w;
   endfunction

   function automatic logic signed [31:0] world_coord();
      return int'($urandom_range(0, 16 * UNIT_Q)) - 8 * UNIT_Q;
   endfunction

   function automatic logic signed [31:0] box_span();
      return int'($urandom_range(UNIT_Q / 16, 4 * UNIT_Q));
   endfunction

   function automatic longint near_offset();
      return longint'($urandom_range(0, 3 * UNIT_Q)) - 3 * UNIT_Q / 2;
   endfunction

   function automatic longint near_corner(input int s, input int a);
      return ($urandom_range(0, 1) ? box_lo[s][a] : box_hi[s][a]) + near_offset();
   endfunction

   // Mostly moves around the colliders in play, with table rewrites and some noise.
   function automatic req_type random_word();
      req_type w;
      logic signed [31:0] swap;
      int pick;
      int s;
      int r;
      w = noise_word();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         w.opcode = OP_NOP;
      end else if (pick < 18) begin
         w.opcode = OP_WRITE_BOX;
         if ($urandom_range(0, 1)) w.axis_mask = 3'd7;
         if ($urandom_range(0, 19) != 0) begin
            w.coord_ax = world_coord();
            w.coord_ay = world_coord();
            w.coord_az = world_coord();
            w.coord_bx = w.coord_ax + box_span();
            w.coord_by = w.coord_ay + box_span();
            w.coord_bz = w.coord_az + box_span();
            if ($urandom_range(0, 9) == 0) begin
               swap = w.coord_ax;
               w.coord_ax = w.coord_bx;
               w.coord_bx = swap;
            end
         end
      end else if (pick < 32) begin
         w.opcode = OP_SET_POS;
         r = $urandom_range(0, 9);
         if (r < 7) begin
            s = $urandom_range(0, COLLIDERS - 1);
            w.coord_ax = 32'(near_corner(s, 0));
            w.coord_ay = 32'(near_corner(s, 1));
            w.coord_az = 32'(near_corner(s, 2));
         end else if (r < 9) begin
            w.coord_ax = world_coord();
            w.coord_ay = world_coord();
            w.coord_az = world_coord();
         end
      end else begin
         w.opcode = OP_MOVE;
         w.move_axis = ($urandom_range(0, 99) < 3) ? AXIS_NONE : 2'($urandom_range(0, 2));
         r = $urandom_range(0, 99);
         if (r < 5) begin
            w.move_delta = '0;
         end else if (r < 10) begin
            w.move_delta = $urandom;
         end else if (r < 13) begin
            w.move_delta = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         end else begin
            w.move_delta = int'($urandom_range(0, 3 * UNIT_Q)) - 3 * UNIT_Q / 2;
         end
      end
      return w;
   endfunction

   task automatic run_random_phase(input int count, input int gap_odds);
      for (int k = 0; k < count; k++) begin
         send_word(random_word());
         if (gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
            pause_sender($urandom_range(1, 18));
         end
         if (gap_odds > 0 && $urandom_range(0, 59) == 0) drain_results();
      end
   endtask

   task automatic test_table_load();
      send_word(box_word(3'd0, 3'd7, -4 * UNIT_Q, -UNIT_Q, -4 * UNIT_Q,
                         4 * UNIT_Q, 0, 4 * UNIT_Q));
      send_word(box_word(3'd1, 3'd1, 2 * UNIT_Q, 0, -4 * UNIT_Q,
                         3 * UNIT_Q, 4 * UNIT_Q, 4 * UNIT_Q));
      send_word(box_word(3'd2, 3'd2, -4 * UNIT_Q, 5 * UNIT_Q, -4 * UNIT_Q,
                         4 * UNIT_Q, 6 * UNIT_Q, 4 * UNIT_Q));
      send_word(box_word(3'd3, 3'd4, -4 * UNIT_Q, 0, -3 * UNIT_Q,
                         4 * UNIT_Q, 4 * UNIT_Q, -2 * UNIT_Q));
      // inverted corners are kept as written
      send_word(box_word(3'd4, 3'd7, 10 * UNIT_Q, 10 * UNIT_Q, 10 * UNIT_Q,
                         9 * UNIT_Q, 9 * UNIT_Q, 9 * UNIT_Q));
      send_word(box_word(3'd5, 3'd0, -8 * UNIT_Q, -8 * UNIT_Q, -8 * UNIT_Q,
                         8 * UNIT_Q, 8 * UNIT_Q, 8 * UNIT_Q));
      send_word(box_word(3'd6, 3'd0, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
      send_word(box_word(3'd7, 3'd7, 20 * UNIT_Q, 20 * UNIT_Q, 20 * UNIT_Q,
                         20 * UNIT_Q + 7, 20 * UNIT_Q + 7, 20 * UNIT_Q + 7));
      // no colliders active yet: plain move
      send_word(move_word(AXIS_Y, -UNIT_Q));
      send_word(box_word(3'd0, 3'd7, -4 * UNIT_Q, -UNIT_Q, -4 * UNIT_Q,
                         4 * UNIT_Q, 0, 4 * UNIT_Q) ^ '0);
      begin
         req_type w;
         w = noise_word();
         w.opcode = OP_NOP;
         send_word(w);
      end
   endtask

   task automatic test_directed_moves();
      drain_results();
      load_regs(HALF_WIDTH_RESET, HALF_HEIGHT_RESET, 31'd8);
      send_word(pos_word(0, UNIT_Q / 2, 0));
      send_word(move_word(AXIS_Y, -UNIT_Q));        // land on the floor
      send_word(move_word(AXIS_X, 2 * UNIT_Q));     // x wall
      send_word(move_word(AXIS_Z, -3 * UNIT_Q));    // z wall from above
      send_word(move_word(AXIS_Y, 4 * UNIT_Q));     // ceiling
      send_word(move_word(AXIS_X, -UNIT_Q));
      send_word(move_word(AXIS_Y, 0));
      send_word(move_word(AXIS_NONE, 5 * UNIT_Q));
   endtask

   task automatic test_saturation();
      send_word(pos_word(Q_MAX, Q_MAX, Q_MAX));
      send_word(move_word(AXIS_X, Q_MAX));
      send_word(pos_word(Q_MIN, Q_MIN, Q_MIN));
      send_word(move_word(AXIS_Y, Q_MIN));
      send_word(move_word(AXIS_Z, -1));
   endtask

   task automatic test_random_traffic();
      drain_results();
      load_regs(HALF_WIDTH_RESET, HALF_HEIGHT_RESET, 31'd8);
      run_random_phase(300, 6);
      drain_results();
      load_regs(31'($urandom_range(0, 2 * UNIT_Q)), 31'($urandom_range(0, 2 * UNIT_Q)),
                31'($urandom_range(0, 8)));
      run_random_phase(200, 4);
   endtask

   task automatic test_register_extremes();
      drain_results();
      load_regs('0, '0, 31'd8);
      run_random_phase(150, 6);
      drain_results();
      load_regs('1, '1, 31'd8);
      run_random_phase(100, 6);
      drain_results();
      // more active entries than the table holds; upper data bits are don't-care
      load_regs(31'($urandom_range(0, 3 * UNIT_Q)), 31'($urandom_range(0, 3 * UNIT_Q)),
                {27'($urandom), 4'd15});
      run_random_phase(200, 8);
   endtask

   task automatic test_back_to_back();
      drain_results();
      load_regs(HALF_WIDTH_RESET, HALF_HEIGHT_RESET, 31'd8);
      run_random_phase(400, 0);
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      body_pos[0] = 0;
      body_pos[1] = 0;
      body_pos[2] = 0;
      half_w = longint'(HALF_WIDTH_RESET);
      half_h = longint'(HALF_HEIGHT_RESET);
      live_boxes = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_table_load();
      test_directed_moves();
      test_saturation();
      test_random_traffic();
      test_register_extremes();
      test_back_to_back();

      drain_results();
      if (fault_count == 0 && body_state_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
